// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl core
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/ale_pkg.sv =====
// package for the array list engine: sizes, command and status codes, fsm states
// no dependencies
`default_nettype none
package ale_pkg;
  localparam int DefDepth = 64;
  localparam int PosW = 6;
  localparam int LenW = 7;
  localparam int ValW = 32;
  localparam int ResW = 38;

  typedef enum logic [3:0] {
    CMD_APPEND = 4'd0, CMD_INSERT = 4'd1, CMD_DELETE = 4'd2, CMD_GET = 4'd3,
    CMD_SET = 4'd4, CMD_LINSRCH = 4'd5, CMD_BINSRCH = 4'd6, CMD_MAX = 4'd7,
    CMD_MIN = 4'd8, CMD_SUM = 4'd9, CMD_REVERSE = 4'd10, CMD_ROTL = 4'd11,
    CMD_ROTR = 4'd12
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_REJECT = 2'd1, ST_NOTFOUND = 2'd2, ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_WAIT, S_EXEC, S_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/ale_if.sv =====
// valid/ready channel interfaces for commands and results
// depends on ale_pkg
`default_nettype none
interface ale_cmd_if;
  logic valid;
  logic ready;
  logic [3:0] command;
  logic [ale_pkg::PosW-1:0] position;
  logic signed [ale_pkg::ValW-1:0] operand_value;
  modport source (output valid, command, position, operand_value, input ready);
  modport sink (input valid, command, position, operand_value, output ready);
endinterface

interface ale_res_if;
  logic valid;
  logic ready;
  logic signed [ale_pkg::ResW-1:0] result_value;
  logic [ale_pkg::PosW-1:0] result_position;
  logic [1:0] status;
  logic [ale_pkg::LenW-1:0] length_now;
  modport source (output valid, result_value, result_position, status, length_now,
                  input ready);
  modport sink (input valid, result_value, result_position, status, length_now,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/array_list_engine_core.sv =====
// array list engine top level: element memory, sequencer and result register
// depends on ale_pkg, ale_if and assert_macros.svh
//
// channel | dir | carries
// cmd     | in  | command, position, operand_value
// res     | out | result_value, result_position, status, length_now
//
// an item with no element read goes from accept straight to done; every memory read
// adds the address, wait and execute states. get reads one element; shifts, searches,
// sum, max, min and rotate read per element walked, reverse two per swapped pair;
// the result is loaded into the output register as the sequencer leaves done.
// the memory holds no reset state; on rst the state, the length and the output valid clear.
// a new command is taken once the previous result has moved into the output
// register; the output register holds while res.ready is low.
`default_nettype none
`include "assert_macros.svh"
module array_list_engine_core #(
  parameter int DEPTH = ale_pkg::DefDepth
) (
  input wire logic clk,
  input wire logic rst,
  ale_cmd_if.sink cmd,
  ale_res_if.source res
);
  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [ale_pkg::ValW-1:0] mem [DEPTH];
  logic [ale_pkg::ValW-1:0] rdata;
  logic [AW-1:0] raddr, waddr;
  logic wen;
  logic [ale_pkg::ValW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  ale_pkg::state_t state, state_next;
  logic [NW-1:0] len, len_next;
  logic [3:0] op;
  logic signed [ale_pkg::ValW-1:0] key;
  // walking indexes; signed and one bit wider for the binary search bounds
  logic signed [NW:0] lo, hi, lo_next, hi_next;
  logic phase, phase_next;
  logic signed [ale_pkg::ValW-1:0] hold, hold_next;
  logic signed [ale_pkg::ResW-1:0] acc, acc_next;
  logic [AW-1:0] fpos, fpos_next;
  logic [1:0] st, st_next;

  logic out_v;
  logic signed [ale_pkg::ResW-1:0] o_val;
  logic [ale_pkg::PosW-1:0] o_pos;
  logic [1:0] o_st;
  logic [ale_pkg::LenW-1:0] o_len;

  logic signed [NW:0] mid;
  logic signed [NW:0] lenx;
  logic [AW-1:0] posw;
  logic signed [ale_pkg::ValW-1:0] rd_s;
  logic take;

  assign cmd.ready = (state == ale_pkg::S_IDLE);
  assign take = cmd.valid && cmd.ready;
  assign rd_s = rdata;
  assign lenx = (NW+1)'(len);
  assign mid = lo + ((hi - lo) >>> 1);
  assign posw = AW'(cmd.position);

  always_comb begin
    state_next = state;
    len_next = len;
    lo_next = lo;
    hi_next = hi;
    phase_next = phase;
    hold_next = hold;
    acc_next = acc;
    fpos_next = fpos;
    st_next = st;
    raddr = lo[AW-1:0];
    waddr = lo[AW-1:0];
    wdata = hold;
    wen = 1'b0;
    case (state)
      ale_pkg::S_IDLE: begin
        if (take) begin
          acc_next = '0;
          fpos_next = '0;
          st_next = ale_pkg::ST_OK;
          phase_next = 1'b0;
          lo_next = '0;
          hi_next = lenx - 1'b1;
          hold_next = cmd.operand_value;
          state_next = ale_pkg::S_DONE;
          case (cmd.command)
            ale_pkg::CMD_APPEND: begin
              if (len < NW'(DEPTH)) begin
                wen = 1'b1;
                waddr = len[AW-1:0];
                wdata = cmd.operand_value;
                len_next = len + 1'b1;
              end else st_next = ale_pkg::ST_REJECT;
            end
            ale_pkg::CMD_INSERT: begin
              if (len < NW'(DEPTH) && NW'(cmd.position) <= len
                  && 32'(cmd.position) < 32'(DEPTH)) begin
                // shift down from the end: hi walks from len-1 to pos
                lo_next = (NW+1)'(posw);
                state_next = ale_pkg::S_READ;
              end else st_next = ale_pkg::ST_REJECT;
            end
            ale_pkg::CMD_DELETE, ale_pkg::CMD_GET, ale_pkg::CMD_SET: begin
              if (NW'(cmd.position) < len && 32'(cmd.position) < 32'(DEPTH)) begin
                lo_next = (NW+1)'(posw);
                if (cmd.command == ale_pkg::CMD_SET) begin
                  wen = 1'b1;
                  waddr = posw;
                  wdata = cmd.operand_value;
                end else state_next = ale_pkg::S_READ;
              end else st_next = ale_pkg::ST_REJECT;
            end
            ale_pkg::CMD_LINSRCH, ale_pkg::CMD_BINSRCH: begin
              st_next = ale_pkg::ST_NOTFOUND;
              if (len != '0) state_next = ale_pkg::S_READ;
            end
            ale_pkg::CMD_MAX, ale_pkg::CMD_MIN: begin
              if (len == '0) st_next = ale_pkg::ST_EMPTY;
              else state_next = ale_pkg::S_READ;
            end
            ale_pkg::CMD_SUM, ale_pkg::CMD_ROTL, ale_pkg::CMD_ROTR: begin
              if (len != '0) state_next = ale_pkg::S_READ;
            end
            ale_pkg::CMD_REVERSE: begin
              if (len > NW'(1)) state_next = ale_pkg::S_READ;
            end
            default: st_next = ale_pkg::ST_REJECT;
          endcase
        end
      end
      ale_pkg::S_READ, ale_pkg::S_WAIT: begin
        // address held through the wait cycle so rdata belongs to it
        case (op)
          ale_pkg::CMD_INSERT: raddr = hi[AW-1:0];
          ale_pkg::CMD_DELETE: raddr = AW'(lo + 1);
          ale_pkg::CMD_BINSRCH: raddr = mid[AW-1:0];
          ale_pkg::CMD_REVERSE: raddr = phase ? lo[AW-1:0] : hi[AW-1:0];
          ale_pkg::CMD_ROTL: raddr = phase ? AW'(lo + 1) : lo[AW-1:0];
          ale_pkg::CMD_ROTR: raddr = phase ? AW'(hi - 1) : hi[AW-1:0];
          default: raddr = lo[AW-1:0];
        endcase
        if (state == ale_pkg::S_READ) state_next = ale_pkg::S_WAIT;
        else state_next = ale_pkg::S_EXEC;
      end
      ale_pkg::S_EXEC: begin
        state_next = ale_pkg::S_READ;
        case (op)
          ale_pkg::CMD_INSERT: begin
            if (hi < lo) begin
              wen = 1'b1;
              waddr = lo[AW-1:0];
              wdata = key;
              len_next = len + 1'b1;
              state_next = ale_pkg::S_DONE;
            end else begin
              wen = 1'b1;
              waddr = AW'(hi + 1);
              wdata = rdata;
              hi_next = hi - 1'b1;
            end
          end
          ale_pkg::CMD_DELETE: begin
            if (lo + 1 >= lenx) begin
              len_next = len - 1'b1;
              state_next = ale_pkg::S_DONE;
            end else begin
              wen = 1'b1;
              waddr = lo[AW-1:0];
              wdata = rdata;
              lo_next = lo + 1'b1;
            end
          end
          ale_pkg::CMD_GET: begin
            acc_next = ale_pkg::ResW'(rd_s);
            state_next = ale_pkg::S_DONE;
          end
          ale_pkg::CMD_LINSRCH: begin
            if (!phase) begin
              if (rd_s == key) begin
                st_next = ale_pkg::ST_OK;
                if (lo == 0) state_next = ale_pkg::S_DONE;
                else begin
                  // fetch the predecessor, move it into the found slot
                  phase_next = 1'b1;
                  lo_next = lo - 1'b1;
                  fpos_next = AW'(lo - 1);
                end
              end else if (lo + 1 >= lenx) state_next = ale_pkg::S_DONE;
              else lo_next = lo + 1'b1;
            end else begin
              wen = 1'b1;
              waddr = AW'(lo + 1);
              wdata = rdata;
              // finish by writing the key in front
              hold_next = key;
              state_next = ale_pkg::S_DONE;
              phase_next = 1'b0;
            end
          end
          ale_pkg::CMD_BINSRCH: begin
            if (rd_s == key) begin
              st_next = ale_pkg::ST_OK;
              fpos_next = mid[AW-1:0];
              state_next = ale_pkg::S_DONE;
            end else begin
              if (rd_s > key) hi_next = mid - 1'b1;
              else lo_next = mid + 1'b1;
              if ((rd_s > key) ? (mid - 1 < lo) : (mid + 1 > hi))
                state_next = ale_pkg::S_DONE;
            end
          end
          ale_pkg::CMD_MAX, ale_pkg::CMD_MIN: begin
            if (lo == 0 || (op == ale_pkg::CMD_MAX ? rd_s > hold : rd_s < hold))
              hold_next = rd_s;
            if (lo + 1 >= lenx) begin
              acc_next = ale_pkg::ResW'(
                (lo == 0 || (op == ale_pkg::CMD_MAX ? rd_s > hold : rd_s < hold))
                ? rd_s : hold);
              state_next = ale_pkg::S_DONE;
            end else lo_next = lo + 1'b1;
          end
          ale_pkg::CMD_SUM: begin
            acc_next = acc + ale_pkg::ResW'(rd_s);
            if (lo + 1 >= lenx) state_next = ale_pkg::S_DONE;
            else lo_next = lo + 1'b1;
          end
          ale_pkg::CMD_REVERSE: begin
            if (!phase) begin
              hold_next = rd_s;
              phase_next = 1'b1;
            end else begin
              wen = 1'b1;
              waddr = hi[AW-1:0];
              wdata = rdata;
              phase_next = 1'b0;
              fpos_next = '0;
              // the saved high element goes to lo on the way through done
              state_next = ale_pkg::S_DONE;
            end
          end
          ale_pkg::CMD_ROTL: begin
            if (!phase) begin
              hold_next = rd_s;
              phase_next = 1'b1;
              if (lo + 1 >= lenx) state_next = ale_pkg::S_DONE;
            end else begin
              wen = 1'b1;
              waddr = lo[AW-1:0];
              wdata = rdata;
              lo_next = lo + 1'b1;
              if (lo + 2 >= lenx) begin
                lo_next = lenx - 1'b1;
                state_next = ale_pkg::S_DONE;
              end
            end
          end
          ale_pkg::CMD_ROTR: begin
            if (!phase) begin
              hold_next = rd_s;
              phase_next = 1'b1;
              if (hi == 0) state_next = ale_pkg::S_DONE;
            end else begin
              wen = 1'b1;
              waddr = hi[AW-1:0];
              wdata = rdata;
              hi_next = hi - 1'b1;
              if (hi <= 1) begin
                hi_next = '0;
                state_next = ale_pkg::S_DONE;
              end
            end
          end
          default: state_next = ale_pkg::S_DONE;
        endcase
      end
      ale_pkg::S_DONE: begin
        // final write for moves that park an element, then hand over
        case (op)
          ale_pkg::CMD_LINSRCH: begin
            if (st == ale_pkg::ST_OK && hold == key) begin
              wen = 1'b1;
              waddr = fpos;
              wdata = key;
            end
          end
          ale_pkg::CMD_REVERSE: begin
            if (hi > lo) begin
              wen = 1'b1;
              waddr = lo[AW-1:0];
              wdata = hold;
            end
          end
          ale_pkg::CMD_ROTL: begin
            wen = 1'b1;
            waddr = lo[AW-1:0];
            wdata = hold;
          end
          ale_pkg::CMD_ROTR: begin
            wen = 1'b1;
            waddr = '0;
            wdata = hold;
          end
          default: ;
        endcase
        if (op == ale_pkg::CMD_REVERSE && hi - 1 > lo + 1) begin
          lo_next = lo + 1'b1;
          hi_next = hi - 1'b1;
          state_next = ale_pkg::S_READ;
        end else if (!out_v || res.ready) state_next = ale_pkg::S_IDLE;
      end
      default: state_next = ale_pkg::S_IDLE;
    endcase
  end

  logic done_xfer;
  // done is left for idle only when the result register is free, and written once
  assign done_xfer = (state == ale_pkg::S_DONE) && (state_next == ale_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ale_pkg::S_IDLE;
      len <= '0;
      out_v <= 1'b0;
    end else begin
      state <= state_next;
      len <= len_next;
      if (res.valid && res.ready) out_v <= 1'b0;
      if (done_xfer) out_v <= 1'b1;
    end
  end

  // the done-state writes above repeat while waiting; they are idempotent
  always_ff @(posedge clk) begin
    lo <= lo_next;
    hi <= hi_next;
    phase <= phase_next;
    hold <= hold_next;
    acc <= acc_next;
    fpos <= fpos_next;
    st <= st_next;
    if (take) begin
      op <= cmd.command;
      key <= cmd.operand_value;
    end
    if (done_xfer) begin
      o_val <= (st == ale_pkg::ST_OK) ? acc : '0;
      o_pos <= (st == ale_pkg::ST_OK) ? ale_pkg::PosW'(fpos) : '0;
      o_st <= st;
      o_len <= ale_pkg::LenW'(len_next);
    end
  end

  assign res.valid = out_v;
  assign res.result_value = o_val;
  assign res.result_position = o_pos;
  assign res.status = o_st;
  assign res.length_now = o_len;

  `ASSERT_IMPL(a_len_bound, clk, rst, 1'b1, len <= NW'(DEPTH))
  `ASSERT_IMPL(a_ready_idle, clk, rst, cmd.ready, state == ale_pkg::S_IDLE)
  `ASSERT_NEXT(a_done_valid, clk, rst, done_xfer, res.valid)
  `ASSERT_IMPL(a_len_step, clk, rst, state != ale_pkg::S_IDLE,
               len_next == len || len_next == len + 1'b1 || len_next == len - 1'b1)
endmodule
`default_nettype wire
